### src/edtm_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance threshold match package
// Shared sizes, request codes and constants for the edit distance block.
// ----------------------------------------------------------------------------
package edtm_pkg;

  localparam int MAX_LEN = 64;

  localparam int REQ_W  = 2;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 7;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int COST_W = $clog2(MAX_LEN + 2);

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  localparam logic [DIST_W-1:0] DIST_CAP = 7'd127;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 7'd2;

endpackage

### src/edtm_if.sv
// ----------------------------------------------------------------------------
// Edit distance threshold match channels
// Valid/ready channels for requests and for reported results.
// ----------------------------------------------------------------------------
interface edtm_req_if;
  logic                         valid;
  logic                         ready;
  logic [edtm_pkg::REQ_W-1:0]   req_type;
  logic [edtm_pkg::SYM_W-1:0]   symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink (input valid, input req_type, input symbol, output ready);
endinterface

interface edtm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [edtm_pkg::DIST_W-1:0]  distance;
  logic                         within_limit;
  logic                         too_long;

  modport source (output valid, output distance, output within_limit, output too_long,
                  input ready);
  modport sink (input valid, input distance, input within_limit, input too_long,
                output ready);
endinterface

### src/edit_distance_threshold_match.sv
// ----------------------------------------------------------------------------
// Edit distance threshold match
// Levenshtein distance between two byte strings, compared with a limit.
//
// Requests arrive on the req channel as valid/ready transactions. An append
// request stores one byte of the first string. A second-string request
// sweeps the stored cost row with one shared min cell, one cell per
// cycle. A finish request reads the final cell of the cost row; in its report
// step, once the output register is free, it places distance, within_limit
// and too_long in the rsp output register, raises rsp valid and
// clears both strings. The block accepts no request while a sweep or a
// report is in progress. A finished result may wait in the output register
// while further append and second-string requests are accepted; a finish
// waits in its report step until the receiver has taken the previous result.
// Bytes beyond 64 per string are dropped and flagged as too long.
// Reset is synchronous: both strings are emptied, the cost row reads as its
// initial values, and max_distance returns to 2. The cfg port writes
// max_distance and is meant to be used only while the block is idle.
// ----------------------------------------------------------------------------
module edit_distance_threshold_match (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [edtm_pkg::DIST_W-1:0] cfg_wr_data,
  edtm_req_if.sink                    req,
  edtm_rsp_if.source                  rsp
);

  localparam int LEN_W = edtm_pkg::LEN_W;
  localparam int IDX_W = edtm_pkg::IDX_W;
  localparam int COST_W = edtm_pkg::COST_W;
  localparam int DIST_W = edtm_pkg::DIST_W;
  localparam int SYM_W = edtm_pkg::SYM_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0]                state;
  logic [IDX_W-1:0]          cnt;
  logic [LEN_W-1:0]          first_length;
  logic [LEN_W-1:0]          second_length;
  logic                      overflow_seen;
  logic [DIST_W-1:0]         max_distance;
  logic [edtm_pkg::MAX_LEN-1:0] row_valid;
  logic [SYM_W-1:0]          sym;
  logic [COST_W-1:0]         diag;
  logic [COST_W-1:0]         left;

  logic [COST_W-1:0]         cost_mem [edtm_pkg::MAX_LEN];
  logic [SYM_W-1:0]          fb_mem [edtm_pkg::MAX_LEN];
  logic [COST_W-1:0]         rd_cost;
  logic [SYM_W-1:0]          rd_fb;
  logic                      rd_valid;
  logic [IDX_W-1:0]          rd_idx;

  logic                      out_valid;
  logic [DIST_W-1:0]         out_distance;
  logic                      out_within;
  logic                      out_too_long;

  logic                      req_fire;
  logic                      out_free;
  logic                      fb_we;
  logic                      cost_we;
  logic                      last_cell;
  logic [IDX_W-1:0]          fin_addr;
  logic [IDX_W-1:0]          rd_addr;
  logic [COST_W-1:0]         above;
  logic [COST_W-1:0]         sub_cost;
  logic [COST_W-1:0]         min_ab;
  logic [COST_W-1:0]         cell_new;
  logic [COST_W-1:0]         fin_value;
  logic [DIST_W-1:0]         dist_sat;

  assign req.ready = (state == ST_IDLE);
  assign req_fire = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.distance = out_distance;
  assign rsp.within_limit = out_within;
  assign rsp.too_long = out_too_long;

  assign fin_addr = IDX_W'(first_length - LEN_W'(1));
  assign last_cell = (LEN_W'(cnt) + LEN_W'(1)) == first_length;

  always_comb begin
    case (state)
      ST_SWEEP: rd_addr = cnt + IDX_W'(1);
      ST_REPORT: rd_addr = fin_addr;
      default: begin
        if (req.req_type == edtm_pkg::REQ_FINISH) begin
          rd_addr = fin_addr;
        end else begin
          rd_addr = '0;
        end
      end
    endcase
  end

  assign fb_we = req_fire && (req.req_type == edtm_pkg::REQ_FIRST) &&
                 (first_length < LEN_W'(edtm_pkg::MAX_LEN));
  assign cost_we = (state == ST_SWEEP);

  // A cell never swept since the last finish or reset reads as its own index plus one.
  assign above = rd_valid ? rd_cost : COST_W'(rd_idx) + COST_W'(1);
  assign sub_cost = diag + ((rd_fb != sym) ? COST_W'(1) : COST_W'(0));
  assign min_ab = (above < left) ? above : left;
  assign cell_new = ((min_ab + COST_W'(1)) < sub_cost) ? min_ab + COST_W'(1) : sub_cost;

  assign fin_value = (first_length == '0) ? COST_W'(second_length) : above;
  assign dist_sat = (int'(fin_value) > int'(edtm_pkg::DIST_CAP)) ? edtm_pkg::DIST_CAP :
                    DIST_W'(fin_value);

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[first_length[IDX_W-1:0]] <= req.symbol;
    end
    if (cost_we) begin
      cost_mem[cnt] <= cell_new;
    end
    rd_cost <= cost_mem[rd_addr];
    rd_fb <= fb_mem[rd_addr];
    rd_valid <= row_valid[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first_length <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      row_valid <= '0;
      max_distance <= edtm_pkg::MAX_DIST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_distance <= cfg_wr_data;
      end
      if (out_valid && rsp.ready && state != ST_REPORT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            case (req.req_type)
              edtm_pkg::REQ_FIRST: begin
                if (first_length < LEN_W'(edtm_pkg::MAX_LEN)) begin
                  first_length <= first_length + LEN_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              edtm_pkg::REQ_SECOND: begin
                if (second_length < LEN_W'(edtm_pkg::MAX_LEN)) begin
                  second_length <= second_length + LEN_W'(1);
                  if (first_length != '0) begin
                    state <= ST_SWEEP;
                  end
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              edtm_pkg::REQ_FINISH: begin
                state <= ST_REPORT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          row_valid[cnt] <= 1'b1;
          if (last_cell) begin
            state <= ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            first_length <= '0;
            second_length <= '0;
            overflow_seen <= 1'b0;
            row_valid <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cnt <= '0;
      sym <= req.symbol;
      diag <= COST_W'(second_length);
      left <= COST_W'(second_length) + COST_W'(1);
    end else if (state == ST_SWEEP) begin
      cnt <= cnt + IDX_W'(1);
      diag <= above;
      left <= cell_new;
    end
    if (state == ST_REPORT && out_free) begin
      out_distance <= dist_sat;
      out_within <= !overflow_seen && (dist_sat <= max_distance);
      out_too_long <= overflow_seen;
    end
  end

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> LEN_W'(cnt) < first_length)
    else $error("sweep counter ran past the first string");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && out_free) |=>
      (first_length == '0 && second_length == '0 && !overflow_seen && rsp.valid))
    else $error("finish did not report and clear the strings");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.within_limit && rsp.too_long))
    else $error("overflowed result reported as within limit");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Edit distance threshold match testbench
// Streams pairs of byte strings through the block, predicts each reported
// distance, within_limit and too_long from a behavioral copy of the cost-row
// update, and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int MAX_LEN = edtm_pkg::MAX_LEN;
  localparam int REQ_W = edtm_pkg::REQ_W;
  localparam int SYM_W = edtm_pkg::SYM_W;
  localparam int DIST_W = edtm_pkg::DIST_W;

  localparam logic [REQ_W-1:0] REQ_FIRST  = edtm_pkg::REQ_FIRST;
  localparam logic [REQ_W-1:0] REQ_SECOND = edtm_pkg::REQ_SECOND;
  localparam logic [REQ_W-1:0] REQ_FINISH = edtm_pkg::REQ_FINISH;
  localparam logic [DIST_W-1:0] DIST_CAP = edtm_pkg::DIST_CAP;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = edtm_pkg::MAX_DIST_RESET;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
    logic              too_long;
  } match_report_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [DIST_W-1:0] cfg_wr_data;

  edtm_req_if req_if ();
  edtm_rsp_if rsp_if ();

  edit_distance_threshold_match u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  logic [SYM_W-1:0] a_bytes [MAX_LEN];
  int               cost_row [MAX_LEN + 1];
  int               a_len;
  int               b_len;
  bit               len_overflow;
  int               limit_reg;
  match_report_t    report_q [$];

  int  errors;
  int  sent_items;
  bit  idling_on;
  int  hold_left;
  int  stall_left;

  always #5 clk = ~clk;

  function automatic void clear_strings();
    a_len = 0;
    b_len = 0;
    len_overflow = 1'b0;
    for (int k = 0; k <= MAX_LEN; k++) cost_row[k] = k;
  endfunction

  function automatic void predict_request(input logic [REQ_W-1:0] kind,
                                          input logic [SYM_W-1:0] sym);
    int diag;
    int above;
    int best;
    int d;
    match_report_t rep;
    case (kind)
      REQ_FIRST: begin
        if (a_len < MAX_LEN) begin
          a_bytes[a_len] = sym;
          a_len++;
        end else begin
          len_overflow = 1'b1;
        end
      end
      REQ_SECOND: begin
        if (b_len < MAX_LEN) begin
          diag = cost_row[0];
          cost_row[0] = b_len + 1;
          for (int k = 1; k <= a_len; k++) begin
            above = cost_row[k];
            best = above + 1;
            if (cost_row[k-1] + 1 < best) best = cost_row[k-1] + 1;
            if (diag + (a_bytes[k-1] != sym) < best) best = diag + (a_bytes[k-1] != sym);
            cost_row[k] = best;
            diag = above;
          end
          b_len++;
        end else begin
          len_overflow = 1'b1;
        end
      end
      REQ_FINISH: begin
        d = cost_row[a_len];
        if (d > int'(DIST_CAP)) d = int'(DIST_CAP);
        rep.distance = d[DIST_W-1:0];
        rep.within_limit = !len_overflow && (d <= limit_reg);
        rep.too_long = len_overflow;
        report_q.push_back(rep);
        clear_strings();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(input int alpha);
    if (alpha == 0) return SYM_W'($urandom_range(0, 255));
    return SYM_W'(8'h61 + $urandom_range(0, alpha - 1));
  endfunction

  function automatic logic [DIST_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIST_W'(MAX_LEN);
      2: return DIST_W'(127);
      default: return DIST_W'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.symbol <= sym;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predict_request(kind, sym);
    if (kind != REQ_UNUSED) sent_items++;
  endtask

  task automatic send_string_byte(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym);
    if ($urandom_range(0, 29) == 0) send_request(REQ_UNUSED, SYM_W'($urandom_range(0, 255)));
    send_request(kind, sym);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    limit_reg = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Shape 0 sends the first string, then the second, then a finish. Shape 1
  // interleaves the two strings, and shape 2 leaves out the finish.
  task automatic send_pair(input int len_a, input int edits, input int alpha, input int shape);
    logic [SYM_W-1:0] a_q [$];
    logic [SYM_W-1:0] b_q [$];
    int op;
    int pos;
    int ia;
    int ib;
    for (int k = 0; k < len_a; k++) a_q.push_back(pick_symbol(alpha));
    b_q = a_q;
    for (int k = 0; k < edits; k++) begin
      op = (b_q.size() == 0) ? 1 : $urandom_range(0, 2);
      case (op)
        0: b_q[$urandom_range(0, b_q.size() - 1)] = pick_symbol(alpha);
        1: begin
          pos = $urandom_range(0, b_q.size());
          b_q.insert(pos, pick_symbol(alpha));
        end
        default: b_q.delete($urandom_range(0, b_q.size() - 1));
      endcase
    end
    ia = 0;
    ib = 0;
    while (ia < a_q.size() || ib < b_q.size()) begin
      if (ia < a_q.size() && (shape != 1 || ib >= b_q.size() || $urandom_range(0, 1) == 0))
      begin
        send_string_byte(REQ_FIRST, a_q[ia]);
        ia++;
      end else begin
        send_string_byte(REQ_SECOND, b_q[ib]);
        ib++;
      end
    end
    if (shape != 2) send_string_byte(REQ_FINISH, SYM_W'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_cases();
    send_request(REQ_FINISH, 8'h00);
    send_request(REQ_FIRST, 8'h00);
    send_request(REQ_FIRST, 8'hFF);
    send_request(REQ_SECOND, 8'hFF);
    send_request(REQ_SECOND, 8'h00);
    send_request(REQ_FINISH, 8'hFF);
    send_request(REQ_UNUSED, 8'hFF);
    send_request(REQ_FIRST, 8'h61);
    send_request(REQ_SECOND, 8'h62);
    send_request(REQ_SECOND, 8'h61);
    send_request(REQ_FIRST, 8'h63);
    send_request(REQ_FINISH, 8'h00);
    send_request(REQ_FIRST, 8'hAA);
    send_request(REQ_FIRST, 8'h55);
    send_request(REQ_FINISH, 8'h00);
    send_request(REQ_SECOND, 8'hAA);
    send_request(REQ_SECOND, 8'h55);
    send_request(REQ_SECOND, 8'h0F);
    send_request(REQ_FINISH, 8'h00);
  endtask

  task automatic test_string_limits();
    write_limit(DIST_W'(MAX_LEN));
    for (int k = 0; k < MAX_LEN; k++) send_request(REQ_FIRST, 8'h00);
    for (int k = 0; k < MAX_LEN; k++) send_request(REQ_SECOND, 8'hFF);
    send_request(REQ_FINISH, 8'h00);
    for (int k = 0; k <= MAX_LEN; k++) send_request(REQ_FIRST, pick_symbol(0));
    send_request(REQ_SECOND, pick_symbol(0));
    send_request(REQ_FINISH, 8'h00);
    for (int k = 0; k <= MAX_LEN; k++) send_request(REQ_SECOND, pick_symbol(0));
    send_request(REQ_FINISH, 8'h00);
  endtask

  task automatic test_limit_settings();
    logic [DIST_W-1:0] values [5];
    values = '{7'd0, 7'd1, DIST_W'(MAX_LEN), 7'd127, pick_limit()};
    foreach (values[i]) begin
      write_limit(values[i]);
      repeat (4) send_pair($urandom_range(0, 8), $urandom_range(0, 3), $urandom_range(1, 3), 0);
    end
  endtask

  task automatic test_output_backpressure();
    idling_on = 1'b0;
    wait_idle();
    hold_left <= 300;
    repeat (6) send_pair($urandom_range(1, 4), $urandom_range(0, 2), 2, 0);
    idling_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int budget);
    int first_count;
    int next_cfg;
    int roll;
    int len;
    int shape;
    first_count = sent_items;
    next_cfg = sent_items + 150;
    while (sent_items - first_count < budget) begin
      if (sent_items >= next_cfg) begin
        write_limit(pick_limit());
        next_cfg = sent_items + 150;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(REQ_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
      end else begin
        len = (roll < 7) ? $urandom_range(60, 70) : $urandom_range(0, 12);
        roll = $urandom_range(0, 99);
        shape = (roll < 80) ? 0 : (roll < 90) ? 1 : 2;
        send_pair(len, $urandom_range(0, 4),
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4), shape);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (report_q.size() == 0) begin
        $error("unexpected result transaction: distance %0d", rsp_if.distance);
        errors++;
      end else begin
        if (rsp_if.distance !== report_q[0].distance) begin
          $error("distance: expected %0d, actual %0d", report_q[0].distance, rsp_if.distance);
          errors++;
        end
        if (rsp_if.within_limit !== report_q[0].within_limit) begin
          $error("within_limit: expected %0b, actual %0b", report_q[0].within_limit,
                 rsp_if.within_limit);
          errors++;
        end
        if (rsp_if.too_long !== report_q[0].too_long) begin
          $error("too_long: expected %0b, actual %0b", report_q[0].too_long, rsp_if.too_long);
          errors++;
        end
        void'(report_q.pop_front());
      end
    end
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    #8_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int waited;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_FIRST;
    req_if.symbol = '0;
    rsp_if.ready = 1'b0;
    errors = 0;
    sent_items = 0;
    idling_on = 1'b1;
    hold_left = 0;
    stall_left = 0;
    limit_reg = int'(MAX_DIST_RESET);
    clear_strings();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_string_limits();
    test_limit_settings();
    test_output_backpressure();
    test_random_traffic(950);
    idling_on = 1'b0;
    test_random_traffic(200);

    req_if.valid <= 1'b0;
    waited = 0;
    while (report_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      $error("%0d expected results never arrived", report_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/edtm_pkg.sv
src/edtm_if.sv
src/edit_distance_threshold_match.sv
verif/tb.sv
